[hdl/csf_pkg.sv]
// Shared constants and types of the carrier-smoothed code filter.
`default_nettype none

package csf_pkg;

  // Field widths
  localparam int SAT_W   = 6;
  localparam int SIG_W   = 3;
  localparam int TIME_W  = 32;
  localparam int RANGE_W = 36;
  localparam int AID_W   = 37;
  localparam int ID_W    = 8;
  localparam int MODE_W  = 2;
  localparam int GAIN_W  = 17;

  localparam int NUM_SATS    = 1 << SAT_W;
  localparam int NUM_SIGNALS = 1 << SIG_W;
  localparam int CH_W        = SAT_W + SIG_W;
  localparam int NUM_CH      = NUM_SATS * NUM_SIGNALS;

  // Datapath widths
  localparam int PRED_W = AID_W + 2;            // last + aid - last_aid
  localparam int DIFF_W = PRED_W + 1;           // code - pred
  localparam int FRAC_W = 16;                   // gain is Q1.16
  localparam int PROD_W = DIFF_W + GAIN_W;      // |diff| * 2^16 fits
  localparam int Q_W    = PROD_W - FRAC_W;
  localparam int RES_W  = Q_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1 << FRAC_W);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DOPPLER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PHASE   = 2'd2;

  // Per-satellite window entry
  typedef struct packed {
    logic              started;
    logic [TIME_W-1:0] start;
  } csf_win_t;

  // Per-channel filter entry
  typedef struct packed {
    logic               used;
    logic [ID_W-1:0]    aid_id;
    logic [AID_W-1:0]   aid;
    logic [RANGE_W-1:0] smoothed;
  } csf_chan_t;

  // Item traveling down the arithmetic pipeline
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [RANGE_W-1:0] code;
    logic [AID_W-1:0]   aid;
    logic [ID_W-1:0]    aid_id;
    logic [PRED_W-1:0]  pred;
    logic               smooth;
    logic               upd;
  } csf_item_t;

endpackage

`default_nettype wire

[hdl/csf_ram.sv]
// Simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module csf_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-during-write to the same address returns the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/csf_arith.sv]
// Filter update pipeline: difference, gain multiply, rounding and saturation.
`default_nettype none

module csf_arith import csf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               a_valid,
  input  csf_item_t          a_item,
  input  logic [GAIN_W-1:0]  gain,
  input  logic [CH_W-1:0]    chk_ch,
  output logic               chk_hit,
  output logic               d_valid,
  output csf_item_t          d_item,
  output logic [RANGE_W-1:0] d_range
);

  logic b_valid_r, c_valid_r, d_valid_r;
  csf_item_t b_item_r, c_item_r, d_item_r;

  logic signed [DIFF_W-1:0]        diff;
  logic signed [DIFF_W-1:0]        c_diff_r;
  logic signed [GAIN_W:0]          gain_s;
  logic signed [DIFF_W+GAIN_W:0]   prod_full;
  logic        [PROD_W-1:0]        d_prod_r;
  logic        [PROD_W-1:0]        rsum;
  logic signed [Q_W-1:0]           q;
  logic signed [PRED_W-1:0]        d_pred;
  logic signed [RES_W-1:0]         res;
  logic        [RANGE_W-1:0]       res_sat;

  // stage B: innovation
  assign diff = $signed({{(DIFF_W-RANGE_W){1'b0}}, b_item_r.code})
              - $signed({b_item_r.pred[PRED_W-1], b_item_r.pred});

  // stage C: weight by gain
  assign gain_s    = $signed({1'b0, gain});
  assign prod_full = c_diff_r * gain_s;

  // stage D: round half up, add back to prediction, clamp
  assign rsum   = d_prod_r + ROUND_HALF;
  assign q      = $signed(rsum[PROD_W-1:FRAC_W]);
  assign d_pred = $signed(d_item_r.pred);
  assign res    = $signed({{(RES_W-PRED_W){d_pred[PRED_W-1]}}, d_pred})
                + $signed({q[Q_W-1], q});

  always_comb begin
    if (res[RES_W-1]) begin
      res_sat = '0;
    end else if (res[RES_W-2:RANGE_W] != '0) begin
      res_sat = '1;
    end else begin
      res_sat = res[RANGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item_r <= a_item;
      c_item_r <= b_item_r;
      c_diff_r <= diff;
      d_item_r <= c_item_r;
      d_prod_r <= prod_full[PROD_W-1:0];
    end
  end

  assign chk_hit = (b_valid_r && b_item_r.ch == chk_ch) ||
                   (c_valid_r && c_item_r.ch == chk_ch) ||
                   (d_valid_r && d_item_r.ch == chk_ch);

  assign d_valid = d_valid_r;
  assign d_item  = d_item_r;
  assign d_range = d_item_r.smooth ? res_sat : d_item_r.code;

endmodule

`default_nettype wire

[hdl/carrier_smoothed_code_filter.sv]
// Top level of the carrier-smoothed code (Hatch) filter.
`default_nettype none

// Takes one observation transfer per clock while in_stall is low and returns
// one result per observation, in order, through stages A (memory read),
// B (difference), C (gain multiply), D (round and clamp) and the output
// register. Per-satellite window state and per-channel filter state sit in
// two synchronous RAMs; the window entry is forwarded to the next item, and
// an observation whose channel (satellite, signal slot) is still in flight
// in stages A to D is held off until that entry is written back, so
// repeated observations of a single channel cannot follow back to back.
// After reset a clearing pass runs over the RAMs with in_stall high;
// configuration writes are taken at any time.
module carrier_smoothed_code_filter import csf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAT_W-1:0]      in_sat_slot,
  input  logic [SIG_W-1:0]      in_signal_slot,
  input  logic [TIME_W-1:0]     in_epoch_time,
  input  logic [RANGE_W-1:0]    in_code_range,
  input  logic signed [AID_W-1:0] in_aid_value,
  input  logic [ID_W-1:0]       in_aid_signal_id,
  input  logic                  in_slip_flag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RANGE_W-1:0]    out_range,
  output logic                  out_is_smoothed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [MODE_W-1:0] smooth_mode_r;
  logic [GAIN_W-1:0] smooth_gain_r;
  logic [TIME_W-1:0] window_ticks_r;
  logic [GAIN_W-1:0] gain_eff;

  // clearing pass
  logic            clearing_r;
  logic            clearing_nxt;
  logic [CH_W-1:0] clr_cnt_r;
  logic [CH_W-1:0] clr_cnt_nxt;
  logic            clr_win;

  // handshake
  logic adv;
  logic accept;
  logic a_hit;
  logic arith_hit;

  // stage A
  logic               a_valid_r;
  logic [SAT_W-1:0]   a_sat_r;
  logic [SIG_W-1:0]   a_sig_r;
  logic [TIME_W-1:0]  a_now_r;
  logic [RANGE_W-1:0] a_code_r;
  logic [AID_W-1:0]   a_aid_r;
  logic [ID_W-1:0]    a_id_r;
  logic               a_slip_r;
  csf_win_t           win_rdata;
  csf_chan_t          chan_rdata;
  csf_win_t           win_cur;
  csf_win_t           win_new;
  logic [TIME_W-1:0]  age;
  logic               restart;
  logic               mode_on;
  logic               a_upd_we;
  logic signed [PRED_W-1:0] ls_e;
  logic signed [PRED_W-1:0] aid_e;
  logic signed [PRED_W-1:0] laid_e;
  csf_item_t          a_item;

  // window forwarding register: last window entry written
  logic             wfwd_valid_r;
  logic [SAT_W-1:0] wfwd_sat_r;
  csf_win_t         wfwd_win_r;

  // RAM ports
  logic             win_we;
  logic [SAT_W-1:0] win_waddr;
  csf_win_t         win_wdata;
  logic             chan_we;
  logic [CH_W-1:0]  chan_waddr;
  csf_chan_t        chan_wdata;

  // stage D and output
  logic               d_valid;
  csf_item_t          d_item;
  logic [RANGE_W-1:0] d_range;
  logic               out_valid_r;
  logic [RANGE_W-1:0] out_range_r;
  logic               out_smoothed_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_mode_r  <= MODE_NONE;
      smooth_gain_r  <= GAIN_ONE;
      window_ticks_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   smooth_mode_r  <= cfg_wdata[MODE_W-1:0];
        REG_GAIN:   smooth_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_WINDOW: window_ticks_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // gains above 1.0 act as 1.0
  assign gain_eff = smooth_gain_r[GAIN_W-1] ? GAIN_ONE : smooth_gain_r;
  assign mode_on  = (smooth_mode_r == MODE_DOPPLER) || (smooth_mode_r == MODE_PHASE);

  // ---------------------------------------------------------- clearing pass
  assign clr_cnt_nxt  = clr_cnt_r + 1'b1;
  assign clearing_nxt = clearing_r && (clr_cnt_r != CH_W'(NUM_CH - 1));
  assign clr_win      = clearing_r && (clr_cnt_r < CH_W'(NUM_SATS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // -------------------------------------------------------------- handshake
  assign adv      = !out_valid_r || !out_stall;
  assign a_hit    = a_valid_r && ({a_sat_r, a_sig_r} == {in_sat_slot, in_signal_slot});
  assign in_stall = clearing_r || !adv || a_hit || arith_hit;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------- stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sat_r  <= in_sat_slot;
      a_sig_r  <= in_signal_slot;
      a_now_r  <= in_epoch_time;
      a_code_r <= in_code_range;
      a_aid_r  <= in_aid_value;
      a_id_r   <= in_aid_signal_id;
      a_slip_r <= in_slip_flag;
    end
  end

  always_comb begin
    win_cur = (wfwd_valid_r && wfwd_sat_r == a_sat_r) ? wfwd_win_r : win_rdata;
    age     = a_now_r - win_cur.start;
    win_new.started = 1'b1;
    if (!win_cur.started || age > window_ticks_r) begin
      win_new.start = a_now_r;
    end else begin
      win_new.start = win_cur.start;
    end
    restart = (win_new.start == a_now_r);

    ls_e   = $signed({{(PRED_W-RANGE_W){1'b0}}, chan_rdata.smoothed});
    aid_e  = $signed({{(PRED_W-AID_W){a_aid_r[AID_W-1]}}, a_aid_r});
    laid_e = $signed({{(PRED_W-AID_W){chan_rdata.aid[AID_W-1]}}, chan_rdata.aid});

    a_item.ch     = {a_sat_r, a_sig_r};
    a_item.code   = a_code_r;
    a_item.aid    = a_aid_r;
    a_item.aid_id = a_id_r;
    if (smooth_mode_r == MODE_PHASE) begin
      a_item.pred = ls_e + aid_e - laid_e;
    end else begin
      a_item.pred = ls_e - aid_e;
    end
    // smoothing off passes the raw range
    a_item.smooth = mode_on && !(restart || !chan_rdata.used ||
                                 chan_rdata.aid_id != a_id_r || a_slip_r);
    a_item.upd    = mode_on;
  end

  assign a_upd_we = a_valid_r && adv && mode_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wfwd_valid_r <= 1'b0;
    end else if (a_upd_we) begin
      wfwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_upd_we) begin
      wfwd_sat_r <= a_sat_r;
      wfwd_win_r <= win_new;
    end
  end

  // ------------------------------------------------------------------ RAMs
  always_comb begin
    if (clearing_r) begin
      win_we     = clr_win;
      win_waddr  = clr_cnt_r[SAT_W-1:0];
      win_wdata  = '0;
      chan_we    = 1'b1;
      chan_waddr = clr_cnt_r;
      chan_wdata = '0;
    end else begin
      win_we     = a_upd_we;
      win_waddr  = a_sat_r;
      win_wdata  = win_new;
      chan_we    = d_valid && adv && d_item.upd;
      chan_waddr = d_item.ch;
      chan_wdata.used     = 1'b1;
      chan_wdata.aid_id   = d_item.aid_id;
      chan_wdata.aid      = d_item.aid;
      chan_wdata.smoothed = d_range;
    end
  end

  csf_ram #(
    .WIDTH ($bits(csf_win_t)),
    .DEPTH (NUM_SATS)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .re    (accept),
    .raddr (in_sat_slot),
    .rdata (win_rdata)
  );

  csf_ram #(
    .WIDTH ($bits(csf_chan_t)),
    .DEPTH (NUM_CH)
  ) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (chan_waddr),
    .wdata (chan_wdata),
    .re    (accept),
    .raddr ({in_sat_slot, in_signal_slot}),
    .rdata (chan_rdata)
  );

  // ------------------------------------------------------- stages B to D
  csf_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .a_valid (a_valid_r),
    .a_item  (a_item),
    .gain    (gain_eff),
    .chk_ch  ({in_sat_slot, in_signal_slot}),
    .chk_hit (arith_hit),
    .d_valid (d_valid),
    .d_item  (d_item),
    .d_range (d_range)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_valid) begin
      out_range_r    <= d_range;
      out_smoothed_r <= d_item.smooth && d_item.upd;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range       = out_range_r;
  assign out_is_smoothed = out_smoothed_r;

endmodule

`default_nettype wire

[hdl/csf_checker.sv]
// Port-level assertions for the carrier-smoothed code filter, bound to the top.
`default_nettype none

module csf_checker import csf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [RANGE_W-1:0]    out_range,
  input logic                  out_is_smoothed,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MAX_PEND = 5;   // stages A..D plus output register

  logic              in_xfer;
  logic              out_xfer;
  logic [2:0]        pend_r;
  logic [MODE_W-1:0] mode_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
    end else if (cfg_we && cfg_index == REG_MODE) begin
      mode_r <= cfg_wdata[MODE_W-1:0];
    end
  end

  // reset starts the clearing pass with an empty output
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input open or output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_range) && $stable(out_is_smoothed))
    else $error("stalled result changed");

  a_smooth_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_smoothed |-> (mode_r == MODE_DOPPLER || mode_r == MODE_PHASE))
    else $error("smoothed result while smoothing is off");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pend_r != '0)
    else $error("result transfer without a pending observation");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'(MAX_PEND))
    else $error("more observations in flight than pipeline stages");

endmodule

bind carrier_smoothed_code_filter csf_checker u_csf_checker (.*);

`default_nettype wire

[test/carrier_smoothed_code_filter_tb.sv]
// Self-checking testbench for the carrier-smoothed code filter: directed corners, then random phases.
module carrier_smoothed_code_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csf_pkg::*;

  localparam int LIMIT       = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_N      = 8;

  localparam logic [MODE_W-1:0]  MODE_SPARE = 2'd3;
  localparam logic [AID_W-1:0]   AID_MIN    = {1'b1, {(AID_W-1){1'b0}}};
  localparam logic [AID_W-1:0]   AID_MAX    = {1'b0, {(AID_W-1){1'b1}}};
  localparam logic [RANGE_W-1:0] CODE_MAX   = '1;
  localparam longint RANGE_TOP = (longint'(1) <<< RANGE_W) - 1;

  typedef struct packed {
    logic [SAT_W-1:0]   sat;
    logic [SIG_W-1:0]   sig;
    logic [TIME_W-1:0]  epoch;
    logic [RANGE_W-1:0] code;
    logic [AID_W-1:0]   aid;
    logic [ID_W-1:0]    aid_id;
    logic               slip;
  } obs_t;

  typedef struct packed {
    logic [RANGE_W-1:0] mm;
    logic               smoothed;
  } range_result_t;

  // Hatch filter predictor plus the queue of ranges still owed by the block
  class range_smoother;
    logic [MODE_W-1:0] mode   = MODE_NONE;
    logic [GAIN_W-1:0] gain   = GAIN_ONE;
    logic [TIME_W-1:0] window = '0;
    bit [TIME_W-1:0]   win_start [NUM_SATS];
    bit                win_started [NUM_SATS];
    longint            ch_smoothed [NUM_CH];
    longint            ch_aid [NUM_CH];
    bit [ID_W-1:0]     ch_aid_id [NUM_CH];
    bit                ch_used [NUM_CH];
    range_result_t     pending [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       smoothed_seen;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:   mode = data[MODE_W-1:0];
        REG_GAIN:   gain = data[GAIN_W-1:0];
        REG_WINDOW: window = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_obs(obs_t o);
      int unsigned       ch;
      logic [TIME_W-1:0] age;
      logic [GAIN_W-1:0] g;
      longint            code_v;
      longint            aid_v;
      longint            pred;
      longint            prod;
      longint            res;
      range_result_t     r;
      r.mm = o.code;
      r.smoothed = 1'b0;
      if (mode == MODE_DOPPLER || mode == MODE_PHASE) begin
        age = o.epoch - win_start[o.sat];
        if (!win_started[o.sat]) begin
          win_started[o.sat] = 1'b1;
          win_start[o.sat] = o.epoch;
        end else if (age > window) begin
          win_start[o.sat] = o.epoch;
        end
        ch = {o.sat, o.sig};
        code_v = longint'(o.code);
        aid_v = longint'(signed'(o.aid));
        if (win_start[o.sat] == o.epoch || !ch_used[ch] || ch_aid_id[ch] != o.aid_id ||
            o.slip) begin
          res = code_v;
        end else begin
          if (mode == MODE_PHASE) begin
            pred = ch_smoothed[ch] + (aid_v - ch_aid[ch]);
          end else begin
            pred = ch_smoothed[ch] - aid_v;
          end
          g = (gain > GAIN_ONE) ? GAIN_ONE : gain;
          prod = (code_v - pred) * longint'(g);
          // round half up: floor((p + 2^15) / 2^16)
          res = pred + ((prod + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
          if (res < 0) res = 0;
          if (res > RANGE_TOP) res = RANGE_TOP;
          r.mm = res[RANGE_W-1:0];
          r.smoothed = 1'b1;
        end
        ch_used[ch] = 1'b1;
        ch_aid_id[ch] = o.aid_id;
        ch_aid[ch] = aid_v;
        ch_smoothed[ch] = res;
      end
      pending.push_back(r);
    endfunction

    function void check_range(logic [RANGE_W-1:0] mm, logic smoothed);
      range_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $error("out transfer with nothing pending: out_range %0d out_is_smoothed %0b",
               mm, smoothed);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.smoothed) smoothed_seen++;
      if (mm !== want.mm) begin
        errors++;
        $error("out_range: expected %0d, got %0d", want.mm, mm);
      end
      if (smoothed !== want.smoothed) begin
        errors++;
        $error("out_is_smoothed: expected %0b, got %0b", want.smoothed, smoothed);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAT_W-1:0]       in_sat_slot;
  logic [SIG_W-1:0]       in_signal_slot;
  logic [TIME_W-1:0]      in_epoch_time;
  logic [RANGE_W-1:0]     in_code_range;
  logic [AID_W-1:0]       in_aid_value;
  logic [ID_W-1:0]        in_aid_signal_id;
  logic                   in_slip_flag;
  logic                   out_valid;
  logic                   out_stall;
  logic [RANGE_W-1:0]     out_range;
  logic                   out_is_smoothed;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  range_smoother sb;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_armed     = 1'b0;
  bit hold_done      = 1'b0;
  int quiet_cycles   = 0;
  int items_sent     = 0;
  int phases_run     = 0;

  // synthetic sky: per-channel code, carrier and aid id that drift slowly
  logic [SAT_W-1:0]   sat_pool [POOL_N];
  logic [TIME_W-1:0]  sky_epoch;
  logic [RANGE_W-1:0] sky_code [NUM_CH];
  logic [AID_W-1:0]   sky_aid [NUM_CH];
  logic [ID_W-1:0]    sky_id [NUM_CH];

  carrier_smoothed_code_filter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sat_slot      (in_sat_slot),
    .in_signal_slot   (in_signal_slot),
    .in_epoch_time    (in_epoch_time),
    .in_code_range    (in_code_range),
    .in_aid_value     (in_aid_value),
    .in_aid_signal_id (in_aid_signal_id),
    .in_slip_flag     (in_slip_flag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_range        (out_range),
    .out_is_smoothed  (out_is_smoothed),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", LIMIT);
      $display("carrier_smoothed_code_filter_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_range(out_range, out_is_smoothed);
    end
  end

  // receiver; the long hold-off lets the pipeline fill and push back on the input
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic obs_t next_obs(input bit dopp);
    obs_t        o;
    int unsigned ch;
    if ($urandom_range(99) < 8) begin
      // noise: any field value, epochs jump both ways
      o.sat    = SAT_W'($urandom);
      o.sig    = SIG_W'($urandom);
      o.epoch  = $urandom;
      o.code   = RANGE_W'({$urandom, $urandom});
      o.aid    = AID_W'({$urandom, $urandom});
      o.aid_id = ID_W'($urandom);
      o.slip   = 1'($urandom);
      return o;
    end
    if ($urandom_range(3) == 0) sky_epoch = sky_epoch + $urandom_range(1, 8);
    o.sat   = sat_pool[$urandom_range(POOL_N - 1)];
    o.sig   = SIG_W'($urandom);
    o.epoch = sky_epoch;
    ch = {o.sat, o.sig};
    if ($urandom_range(99) < 4) sky_id[ch] = ID_W'($urandom);
    if ($urandom_range(99) < 3) begin
      sky_code[ch] = RANGE_W'({$urandom, $urandom});
    end else begin
      sky_code[ch] = sky_code[ch] + RANGE_W'($urandom_range(3000)) - RANGE_W'(1500);
    end
    sky_aid[ch] = sky_aid[ch] + AID_W'($urandom_range(3000)) - AID_W'(1500);
    o.code   = sky_code[ch];
    o.aid    = dopp ? AID_W'($urandom_range(4000)) - AID_W'(2000) : sky_aid[ch];
    o.aid_id = sky_id[ch];
    o.slip   = ($urandom_range(99) < 3);
    return o;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_obs(input obs_t o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_sat_slot      = o.sat;
    in_signal_slot   = o.sig;
    in_epoch_time    = o.epoch;
    in_code_range    = o.code;
    in_aid_value     = o.aid;
    in_aid_signal_id = o.aid_id;
    in_slip_flag     = o.slip;
    in_valid         = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_obs(o);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(input int sat, input int sig, input logic [TIME_W-1:0] ep,
                             input logic [RANGE_W-1:0] code, input logic [AID_W-1:0] aid,
                             input int id, input bit slip);
    obs_t o;
    o.sat    = SAT_W'(sat);
    o.sig    = SIG_W'(sig);
    o.epoch  = ep;
    o.code   = code;
    o.aid    = aid;
    o.aid_id = ID_W'(id);
    o.slip   = slip;
    send_obs(o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  // every item yields one result, so an empty queue means the pipeline is empty
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] m, input logic [GAIN_W-1:0] g,
                           input logic [TIME_W-1:0] w, input int sidle, input int rstall,
                           input int n, input bit dopp, input bit press);
    int i;
    settle();
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_GAIN, CFG_DATA_W'(g));
    write_reg(REG_WINDOW, w);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (i = 0; i < POOL_N; i++) sat_pool[i] = SAT_W'($urandom);
    sky_epoch  = $urandom;
    hold_armed = press;
    repeat (n) send_obs(next_obs(dopp));
    phases_run++;
  endtask

  initial begin
    int i;
    sb = new;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_sat_slot      = '0;
    in_signal_slot   = '0;
    in_epoch_time    = '0;
    in_code_range    = '0;
    in_aid_value     = '0;
    in_aid_signal_id = '0;
    in_slip_flag     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_MODE;
    cfg_wdata        = '0;
    for (i = 0; i < NUM_CH; i++) begin
      sky_code[i] = RANGE_W'({$urandom, $urandom});
      sky_aid[i]  = AID_W'({$urandom, $urandom});
      sky_id[i]   = ID_W'($urandom);
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset configuration: no smoothing, ranges pass raw
    send_fields(63, 7, '1, CODE_MAX, AID_MIN, 255, 1'b1);
    send_fields(0, 0, '0, '0, '0, 0, 1'b0);

    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_PHASE));
    write_reg(REG_GAIN, 16384);
    write_reg(REG_WINDOW, 1000);
    send_fields(0, 0, 100, 1000000, 0, 5, 1'b0);      // first sighting
    send_fields(0, 0, 101, 1000100, 50, 5, 1'b0);     // smoothed
    send_fields(0, 0, 102, 1000200, 60, 6, 1'b0);     // aid id changed
    send_fields(0, 0, 103, 1000300, 70, 6, 1'b1);     // slip
    send_fields(0, 1, 103, 2000000, 70, 6, 1'b0);     // unused channel
    send_fields(1, 0, 200, 5000, 0, 1, 1'b0);
    send_fields(1, 1, 200, 5000, 0, 1, 1'b0);
    send_fields(1, 0, 200, 6000, 10, 1, 1'b0);        // same epoch as window start
    send_fields(0, 0, 50, 1000400, 80, 6, 1'b0);      // time went backwards
    send_fields(0, 0, 1051, 1000500, 90, 6, 1'b0);    // window aged out
    send_fields(0, 0, 1052, 1000, 20, 6, 1'b0);
    send_fields(2, 3, 10, CODE_MAX, AID_MIN, 9, 1'b0);
    send_fields(2, 3, 11, CODE_MAX, AID_MAX, 9, 1'b0);  // clamps high
    send_fields(3, 4, 10, '0, AID_MAX, 9, 1'b0);
    send_fields(3, 4, 11, '0, AID_MIN, 9, 1'b0);        // clamps at zero

    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_DOPPLER));
    write_reg(REG_GAIN, 0);
    write_reg(REG_WINDOW, '1);
    send_fields(4, 7, 5, 123456, 0, 3, 1'b0);
    send_fields(4, 7, 6, 999, -AID_W'(1000), 3, 1'b0);  // zero gain gives the prediction

    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
    write_reg(REG_GAIN, CFG_DATA_W'({GAIN_W{1'b1}}));
    send_fields(4, 7, 7, 777, 1, 3, 1'b0);

    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_DOPPLER));
    write_reg(REG_WINDOW, 1000);
    send_fields(4, 7, 8, 5555, 5, 3, 1'b0);             // oversized gain acts as one
    settle();
    write_reg(REG_WINDOW, 0);
    send_fields(4, 7, 9, 6666, 5, 3, 1'b0);
    send_fields(4, 7, 9, 7777, 5, 3, 1'b0);

    run_phase(MODE_PHASE, 8192, 300, 0, 0, 300, 1'b0, 1'b0);
    run_phase(MODE_DOPPLER, 1, '1, 63, 0, 250, 1'b1, 1'b0);
    run_phase(MODE_PHASE, GAIN_W'($urandom_range(1, 65536)), $urandom_range(20, 2000),
              0, 63, 300, 1'b0, 1'b0);
    run_phase(MODE_PHASE, GAIN_ONE, 100, 15, 15, 250, 1'b0, 1'b0);
    run_phase(MODE_DOPPLER, GAIN_W'($urandom_range(1, 65536)), 500, 0, 0, 200, 1'b1, 1'b1);
    run_phase(MODE_DOPPLER, 32768, 1000, 0, 63, 250, 1'b1, 1'b0);

    settle();
    repeat (10) @(negedge clk);
    $display("covered %0d observations: directed corners and %0d random phases", items_sent,
             phases_run);
    $display("%0d results checked, %0d expected smoothed, %0d mismatches", sb.checked,
             sb.smoothed_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("carrier_smoothed_code_filter_tb: clean");
    end else begin
      $display("carrier_smoothed_code_filter_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/csf_pkg.sv
hdl/csf_ram.sv
hdl/csf_arith.sv
hdl/carrier_smoothed_code_filter.sv
hdl/csf_checker.sv
test/carrier_smoothed_code_filter_tb.sv
